[hw/rtl/rmsn_pkg.sv]
// ----------------------------------------------------------------------------
// rmsn_pkg
// Shared types and constants of the RMS row normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package rmsn_pkg;

    localparam int MAX_WIDTH_DEF = 64;
    localparam int DATA_W        = 16;
    localparam int CNT_W         = 7;
    localparam int SUM_W         = 37;
    localparam int CH_W          = 6;
    localparam int CH_DEPTH      = 64;
    localparam int EPS_W         = 16;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AFFINE_ENABLE = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_WEIGHT = 1'b1;

    // one finished row handed from the front to the back
    typedef struct packed {
        logic [CNT_W-1:0] len;
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
    } job_t;

endpackage

`default_nettype wire

[hw/rtl/rmsn_ram.sv]
// ----------------------------------------------------------------------------
// rmsn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rmsn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/rmsn_front.sv]
// ----------------------------------------------------------------------------
// rmsn_front
// Takes items, stores samples and weights, sums squares, queues finished rows.
// ----------------------------------------------------------------------------
`default_nettype none

module rmsn_front #(
    parameter int MAX_WIDTH = rmsn_pkg::MAX_WIDTH_DEF,
    parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic                          operation,
    input  wire logic [rmsn_pkg::CH_W-1:0]     channel_index,
    input  wire logic [rmsn_pkg::DATA_W-1:0]   data_value,
    input  wire logic [rmsn_pkg::CNT_W-1:0]    len_eff,
    input  wire logic                          job_pop,
    output logic                               job_valid,
    output rmsn_pkg::job_t                     job,
    output logic                               row_we,
    output logic [AW-1:0]                      row_waddr,
    output logic                               wt_we,
    output logic [rmsn_pkg::CH_W-1:0]          wt_waddr,
    output logic [rmsn_pkg::DATA_W-1:0]        wr_data
);
    import rmsn_pkg::*;

    logic [CNT_W-1:0]           count_reg, count_next, count_inc;
    logic [SUM_W-1:0]           sum_reg, sum_next, sum_add;
    logic                       job_valid_reg, job_valid_next;
    job_t                       job_reg, job_next;
    logic signed [2*DATA_W-1:0] sq;
    logic                       is_sample, row_end;

    assign is_sample = accept && (operation == OP_SAMPLE);
    assign sq        = $signed(data_value) * $signed(data_value);
    assign sum_add   = sum_reg + SUM_W'(unsigned'(sq));
    assign count_inc = count_reg + CNT_W'(1);
    assign row_end   = count_inc >= len_eff;

    assign row_we    = is_sample;
    assign row_waddr = count_reg[AW-1:0];
    assign wt_we     = accept && (operation == OP_WEIGHT);
    assign wt_waddr  = channel_index;
    assign wr_data   = data_value;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        count_next     = count_reg;
        sum_next       = sum_reg;
        job_valid_next = job_valid_reg && !job_pop;
        job_next       = job_reg;
        if (is_sample)
        begin
            if (row_end)
            begin
                job_next.len   = len_eff;
                job_next.count = count_inc;
                job_next.sum   = sum_add;
                job_valid_next = 1'b1;
                count_next     = '0;
                sum_next       = '0;
            end
            else
            begin
                count_next = count_inc;
                sum_next   = sum_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule

`default_nettype wire

[hw/rtl/rmsn_back.sv]
// ----------------------------------------------------------------------------
// rmsn_back
// Divides, finds the inverse square root and streams out the scaled row.
// ----------------------------------------------------------------------------
`default_nettype none

module rmsn_back #(
    parameter int MAX_WIDTH = rmsn_pkg::MAX_WIDTH_DEF,
    parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          job_valid,
    input  rmsn_pkg::job_t                     job,
    input  wire logic [rmsn_pkg::EPS_W-1:0]    epsilon,
    input  wire logic                          affine_enable,
    output logic                               job_pop,
    output logic                               busy,
    output logic [AW-1:0]                      row_raddr,
    output logic [rmsn_pkg::CH_W-1:0]          wt_raddr,
    input  wire logic [rmsn_pkg::DATA_W-1:0]   row_rdata,
    input  wire logic [rmsn_pkg::DATA_W-1:0]   wt_rdata,
    output logic [rmsn_pkg::DATA_W-1:0]        normalized_value,
    output logic                               last_of_row,
    output logic                               done
);
    import rmsn_pkg::*;

    localparam int INV_W = 41;
    localparam int MS_W  = SUM_W + 1;
    localparam int ACC_W = 122;
    localparam int P_W   = DATA_W + INV_W + 1;
    localparam int M_W   = 2 * DATA_W;
    localparam logic [ACC_W-1:0] LIMIT = ACC_W'(1) << 80;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_MS, S_ISQ, S_EMIT, S_DRAIN} state_t;

    state_t                 state_reg;
    logic [5:0]             step_reg;
    logic [SUM_W-1:0]       div_reg;
    logic [CNT_W-1:0]       rem_reg, len_reg, num_reg, idx_reg;
    logic [MS_W-1:0]        ms_reg;
    logic [ACC_W-1:0]       s_reg, a_reg, b_reg;
    logic [INV_W-1:0]       q_reg;
    logic                   v1_reg, v2_reg, v3_reg, v4_reg;
    logic                   l1_reg, l2_reg, l3_reg, l4_reg;
    logic signed [P_W-1:0]  p2_reg;
    logic [DATA_W-1:0]      w2_reg, w3_reg, y3_reg, y4_reg;
    logic signed [M_W-1:0]  m4_reg;
    logic [DATA_W-1:0]      out_reg;
    logic                   last_reg, done_reg;

    logic [CNT_W:0]         rem_sh;
    logic                   ge;
    logic [MS_W-1:0]        ms_c;
    logic [ACC_W-1:0]       trial;
    logic                   fit;
    logic                   issue;
    logic signed [P_W-1:0]  p_c, p_rnd, p_sh;
    logic [DATA_W-1:0]      y_c, wy_c;
    logic signed [M_W-1:0]  m_rnd, m_sh;

    assign rem_sh = {rem_reg, div_reg[SUM_W-1]};
    assign ge     = rem_sh >= {1'b0, len_reg};
    assign ms_c   = MS_W'(div_reg) + MS_W'(epsilon);
    assign trial  = s_reg + a_reg + b_reg;
    assign fit    = trial <= LIMIT;
    assign issue  = (state_reg == S_EMIT);

    assign row_raddr = idx_reg[AW-1:0];
    assign wt_raddr  = idx_reg[CH_W-1:0];
    assign job_pop   = (state_reg == S_IDLE) && job_valid;
    assign busy      = (state_reg != S_IDLE);

    assign p_c   = P_W'($signed(row_rdata)) * P_W'($signed({1'b0, q_reg}));
    assign p_rnd = p2_reg + (P_W'(1) <<< 28);
    assign p_sh  = p_rnd >>> 29;
    assign m_rnd = m4_reg + (M_W'(1) <<< 10);
    assign m_sh  = m_rnd >>> 11;

    always_comb
    begin
        if (p_sh > P_W'(32767))
        begin
            y_c = 16'h7FFF;
        end
        else if (p_sh < -P_W'(32768))
        begin
            y_c = 16'h8000;
        end
        else
        begin
            y_c = p_sh[DATA_W-1:0];
        end
        if (m_sh > M_W'(32767))
        begin
            wy_c = 16'h7FFF;
        end
        else if (m_sh < -M_W'(32768))
        begin
            wy_c = 16'h8000;
        end
        else
        begin
            wy_c = m_sh[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            idx_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            v1_reg   <= issue;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(SUM_W - 1))
                    begin
                        state_reg <= S_MS;
                    end
                end
                S_MS:
                begin
                    step_reg  <= '0;
                    state_reg <= S_ISQ;
                end
                S_ISQ:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(INV_W - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                    if (idx_reg == num_reg - CNT_W'(1))
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (!v1_reg && !v2_reg && !v3_reg && !v4_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                len_reg <= job.len;
                num_reg <= job.count;
                div_reg <= job.sum;
                rem_reg <= '0;
            end
            S_DIV:
            begin
                rem_reg <= ge ? CNT_W'(rem_sh - {1'b0, len_reg}) : rem_sh[CNT_W-1:0];
                div_reg <= {div_reg[SUM_W-2:0], ge};
            end
            S_MS:
            begin
                ms_reg <= ms_c;
                s_reg  <= '0;
                a_reg  <= '0;
                b_reg  <= ACC_W'(ms_c) << 80;
                q_reg  <= '0;
            end
            S_ISQ:
            begin
                // trial adds 2q*2^k*ms + 4^k*ms to q^2*ms
                if (fit)
                begin
                    s_reg <= trial;
                end
                a_reg <= (a_reg >> 1) + (fit ? b_reg : '0);
                b_reg <= b_reg >> 2;
                if (step_reg == 6'(INV_W - 1) && ms_reg == '0)
                begin
                    q_reg <= INV_W'(1) << (INV_W - 1);
                end
                else
                begin
                    q_reg <= {q_reg[INV_W-2:0], fit};
                end
            end
            default:
            begin
            end
        endcase
        l1_reg   <= (idx_reg == num_reg - CNT_W'(1));
        p2_reg   <= p_c;
        w2_reg   <= wt_rdata;
        l2_reg   <= l1_reg;
        y3_reg   <= y_c;
        w3_reg   <= w2_reg;
        l3_reg   <= l2_reg;
        m4_reg   <= $signed(y3_reg) * $signed(w3_reg);
        y4_reg   <= y3_reg;
        l4_reg   <= l3_reg;
        out_reg  <= affine_enable ? wy_c : y4_reg;
        last_reg <= l4_reg;
    end

    assign normalized_value = out_reg;
    assign last_of_row      = last_reg && done_reg;
    assign done             = done_reg;

endmodule

`default_nettype wire

[hw/rtl/rms_normalize_row_unit.sv]
// ----------------------------------------------------------------------------
// rms_normalize_row_unit
// RMS normalization of rows of Q7.8 samples into Q4.11 results.
// ----------------------------------------------------------------------------
// Each sample or weight write is taken while busy is low. The sample that
// completes a row raises busy: the back end then picks the row up, runs a
// restoring divide by the row length, adds epsilon, runs a bit-by-bit inverse
// square root, and streams the row out of its buffer at one result per cycle
// through a five-stage read, multiply and round pipeline, which it drains
// before busy falls. Results appear on done for one cycle each and cannot be
// held off. Buffers need no clearing.
`default_nettype none

module rms_normalize_row_unit #(
    parameter int MAX_WIDTH = rmsn_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              operation,
    input  wire logic [rmsn_pkg::CH_W-1:0]         channel_index,
    input  wire logic [rmsn_pkg::DATA_W-1:0]       data_value,
    output logic [rmsn_pkg::DATA_W-1:0]            normalized_value,
    output logic                                   last_of_row,
    output logic                                   done,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rmsn_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rmsn_pkg::DATA_W-1:0]       cfg_data
);
    import rmsn_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [CNT_W-1:0]  row_length_reg, len_eff;
    logic [EPS_W-1:0]  epsilon_reg;
    logic              affine_reg;
    logic              accept, job_valid, job_pop, back_busy;
    job_t              job;
    logic              row_we, wt_we;
    logic [AW-1:0]     row_waddr, row_raddr;
    logic [CH_W-1:0]   wt_waddr, wt_raddr;
    logic [DATA_W-1:0] wr_data, row_rdata, wt_rdata;

    assign cfg_ready = 1'b1;
    assign busy      = job_valid || back_busy;
    assign accept    = start && !busy;

    always_comb
    begin
        if (row_length_reg == '0)
        begin
            len_eff = CNT_W'(1);
        end
        else if (row_length_reg > CNT_W'(MAX_WIDTH))
        begin
            len_eff = CNT_W'(MAX_WIDTH);
        end
        else
        begin
            len_eff = row_length_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= CNT_W'(64);
            epsilon_reg    <= EPS_W'(1);
            affine_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROW_LENGTH:    row_length_reg <= cfg_data[CNT_W-1:0];
                REG_EPSILON:       epsilon_reg    <= cfg_data;
                REG_AFFINE_ENABLE: affine_reg     <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    rmsn_front #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_front (
        .clk(clk), .rst_n(rst_n), .accept(accept), .operation(operation),
        .channel_index(channel_index), .data_value(data_value), .len_eff(len_eff),
        .job_pop(job_pop), .job_valid(job_valid), .job(job),
        .row_we(row_we), .row_waddr(row_waddr), .wt_we(wt_we),
        .wt_waddr(wt_waddr), .wr_data(wr_data)
    );

    rmsn_ram #(.WIDTH(DATA_W), .DEPTH(MAX_WIDTH), .AW(AW)) u_row_buf (
        .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(wr_data),
        .raddr(row_raddr), .rdata(row_rdata)
    );

    rmsn_ram #(.WIDTH(DATA_W), .DEPTH(CH_DEPTH), .AW(CH_W)) u_wt_tab (
        .clk(clk), .we(wt_we), .waddr(wt_waddr), .wdata(wr_data),
        .raddr(wt_raddr), .rdata(wt_rdata)
    );

    rmsn_back #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job(job),
        .epsilon(epsilon_reg), .affine_enable(affine_reg), .job_pop(job_pop),
        .busy(back_busy), .row_raddr(row_raddr), .wt_raddr(wt_raddr),
        .row_rdata(row_rdata), .wt_rdata(wt_rdata),
        .normalized_value(normalized_value), .last_of_row(last_of_row), .done(done)
    );

`ifndef SYNTHESIS
    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result outside a busy period");
    a_row_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last_of_row) |=> done)
        else $error("gap inside a row of results");
    a_last_marks_done: assert property (@(posedge clk) disable iff (!rst_n)
        last_of_row |-> done)
        else $error("last_of_row without a result");
    a_no_accept_after_row: assert property (@(posedge clk) disable iff (!rst_n)
        (done && last_of_row) |-> !$past(accept && operation == OP_SAMPLE))
        else $error("sample taken while a row drained");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks rms_normalize_row_unit against a cycle-free predictor of the row
// normalization, over directed corner rows and randomized configuration phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import rmsn_pkg::*;

    typedef struct {
        logic             op;
        logic [CH_W-1:0]  ch;
        logic [15:0]      data;
    } beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 operation = OP_SAMPLE;
    logic [CH_W-1:0]      channel_index = '0;
    logic [DATA_W-1:0]    data_value = '0;
    logic [DATA_W-1:0]    normalized_value;
    logic                 last_of_row;
    logic                 done;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;

    rms_normalize_row_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .channel_index(channel_index),
        .data_value(data_value), .normalized_value(normalized_value),
        .last_of_row(last_of_row), .done(done), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state
    logic [6:0]          len_reg = 7'd64;
    logic [15:0]         eps_reg = 16'd1;
    logic                aff_reg = 1'b0;
    logic signed [15:0]  row_samples [64];
    logic signed [15:0]  weights [64];
    logic [36:0]         sq_sum = '0;
    int                  sample_cnt = 0;

    beat_t               pending_q[$];
    beat_t               cur;
    logic [15:0]         want_val[$];
    logic                want_last[$];
    int                  errors = 0;
    bit                  no_gap = 0;

    function automatic logic [40:0] inv_root(logic [31:0] ms);
        logic [127:0] lo, hi, mid;
        lo = 0;
        hi = 128'd1 << 40;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (mid * mid * ms <= (128'd1 << 80))
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo[40:0];
    endfunction

    function automatic longint round_clip(longint v, int s);
        longint r;
        r = (v + (longint'(1) << (s - 1))) >>> s;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    function automatic void normalize_beat(beat_t b);
        int     len;
        longint y;
        logic [31:0] ms;
        logic [40:0] inv;
        logic signed [15:0] x;
        x = b.data;
        if (b.op == OP_WEIGHT) begin
            weights[b.ch] = x;
            return;
        end
        len = len_reg;
        if (len < 1) len = 1;
        if (len > 64) len = 64;
        if (sample_cnt < 64) row_samples[sample_cnt] = x;
        sq_sum = sq_sum + 37'(longint'(x) * longint'(x));
        sample_cnt++;
        if (sample_cnt < len) return;
        ms = 32'(sq_sum / len) + eps_reg;
        inv = inv_root(ms);
        for (int i = 0; i < sample_cnt && i < 64; i++) begin
            y = round_clip(longint'(row_samples[i]) * longint'(inv), 29);
            if (aff_reg) y = round_clip(y * longint'(weights[i]), 11);
            want_val.push_back(16'(y));
            want_last.push_back(i == sample_cnt - 1 || i == 63);
        end
        sq_sum = '0;
        sample_cnt = 0;
    endfunction

    task automatic report(string what, logic [15:0] got, logic [15:0] exp_v);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, exp_v, $realtime);
        errors++;
    endtask

    // driver: hold a beat while busy, otherwise advance or idle
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start <= 1'b0;
        end
        else begin
            if (start && !busy) normalize_beat(cur);
            if (!(start && busy)) begin
                if (pending_q.size() > 0 && (no_gap || $urandom_range(99) >= 21)) begin
                    cur = pending_q.pop_front();
                    start <= 1'b1;
                    operation <= cur.op;
                    channel_index <= cur.ch;
                    data_value <= cur.data;
                end
                else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (want_val.size() == 0) begin
                report("unexpected result", normalized_value, 16'h0);
            end
            else begin
                if (normalized_value !== want_val[0])
                    report("value", normalized_value, want_val[0]);
                if (last_of_row !== want_last[0])
                    report("last_of_row", 16'(last_of_row), 16'(want_last[0]));
                void'(want_val.pop_front());
                void'(want_last.pop_front());
            end
        end
    end

    function automatic void push_beat(logic op, logic [CH_W-1:0] ch, logic [15:0] d);
        beat_t b;
        b.op = op;
        b.ch = ch;
        b.data = d;
        pending_q.push_back(b);
    endfunction

    function automatic logic [15:0] rand_sample();
        if ($urandom_range(99) < 30) return 16'($urandom);
        return 16'($urandom_range(1023)) - 16'd512;
    endfunction

    task automatic settle();
        do @(posedge clk);
        while (pending_q.size() > 0 || start || want_val.size() > 0);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        logic rdy;
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        forever begin
            @(negedge clk);
            rdy = cfg_ready;
            @(posedge clk);
            if (rdy) break;
        end
        cfg_valid <= 1'b0;
        if (idx == REG_ROW_LENGTH) len_reg = val[6:0];
        else if (idx == REG_EPSILON) eps_reg = val;
        else if (idx == REG_AFFINE_ENABLE) aff_reg = val[0];
    endtask

    task automatic random_rows(int budget);
        int len;
        len = len_reg;
        if (len < 1) len = 1;
        if (len > 64) len = 64;
        while (budget > 0) begin
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(99) < 8)
                    push_beat(OP_WEIGHT, 6'($urandom), 16'($urandom));
                push_beat(OP_SAMPLE, 6'($urandom), rand_sample());
            end
            budget -= len;
        end
    endtask

    initial begin
        int lens[4];
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // load every weight so affine rows never read an empty entry
        for (int c = 0; c < 64; c++)
            push_beat(OP_WEIGHT, 6'(c), (c == 0) ? 16'h7fff : (c == 1) ? 16'h8000 :
                      16'd2048 + 16'($urandom_range(511)) - 16'd256);
        settle();

        // single-sample rows: extremes, zero with no epsilon, affine on
        write_reg(REG_ROW_LENGTH, 16'd1);
        write_reg(REG_EPSILON, 16'd0);
        write_reg(REG_AFFINE_ENABLE, 16'd1);
        push_beat(OP_SAMPLE, 6'h3f, 16'h7fff);
        push_beat(OP_SAMPLE, 6'h00, 16'h8000);
        push_beat(OP_SAMPLE, 6'h2a, 16'h0000);
        push_beat(OP_SAMPLE, 6'h15, 16'h0001);
        settle();
        // row length of zero acts as one
        write_reg(REG_ROW_LENGTH, 16'd0);
        push_beat(OP_SAMPLE, 6'h00, 16'hffff);
        settle();

        // lower the row length mid-row: the next sample closes the row
        write_reg(REG_AFFINE_ENABLE, 16'd0);
        write_reg(REG_EPSILON, 16'hffff);
        write_reg(REG_ROW_LENGTH, 16'd8);
        for (int i = 0; i < 5; i++) push_beat(OP_SAMPLE, 6'(i), rand_sample());
        settle();
        write_reg(REG_ROW_LENGTH, 16'd3);
        push_beat(OP_SAMPLE, 6'h0, 16'h7fff);
        settle();

        // oversize length acts as the maximum
        write_reg(REG_ROW_LENGTH, 16'd127);
        write_reg(REG_EPSILON, 16'd1);
        random_rows(64);
        settle();

        lens = '{32, 1, 3, 17};
        for (int p = 0; p < 8; p++) begin
            no_gap = (p == 3);
            write_reg(REG_ROW_LENGTH, (p < 4) ? 16'(lens[p]) : 16'($urandom_range(1, 20)));
            write_reg(REG_EPSILON, (p % 3 == 0) ? 16'hffff : (p % 3 == 1) ? 16'd0 :
                      16'($urandom));
            write_reg(REG_AFFINE_ENABLE, 16'($urandom_range(1)));
            random_rows((p == 3) ? 34 : 8);
            settle();
        end
        no_gap = 0;

        if (errors == 0 && want_val.size() == 0) begin
            $display("DONE: 0 errors");
        end
        else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #7200000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
